// ----- rtl/core/logsin_exp_operator_output_macros.svh -----
// assertion macros for the operator output stage
// used by files that carry concurrent assertions; clock clk, reset arst_n
`ifndef LOGSIN_EXP_OPERATOR_OUTPUT_MACROS_SVH
`define LOGSIN_EXP_OPERATOR_OUTPUT_MACROS_SVH

`ifndef ASSERT_OFF
`define LSE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("operator output check failed");
`define LSE_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("operator output forbidden condition");
`else
`define LSE_ASSERT(label, prop)
`define LSE_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- rtl/core/lsexp_pkg.sv -----
// types, widths and rom tables for the operator output stage
// tables are built at elaboration with fixed-point constant functions; no dependencies
package lsexp_pkg;

	localparam int PHASE_W = 10;
	localparam int ATT_W   = 12;
	localparam int LOGSIN_W = 12;
	localparam int EXP_W   = 10;
	localparam int LEVEL_W = 13;
	localparam int MAG_W   = 12;
	localparam int SAMPLE_W = 9;
	localparam int ROM_DEPTH = 256;

	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
	localparam logic [63:0] TWO_Q62 = 64'h8000000000000000;
	localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
	localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;
	localparam logic [63:0] PI_STEP = PI_Q62 / 1024;

	typedef logic [ROM_DEPTH-1:0][LOGSIN_W-1:0] logsin_tbl_t;
	typedef logic [ROM_DEPTH-1:0][EXP_W-1:0]    exp_tbl_t;

	// level in log units and the sign of the half wave
	typedef struct packed {
		logic               neg;
		logic [LEVEL_W-1:0] level;
	} lsexp_lvl_t;

	// (a * b) >> 62, elaboration only
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// unsigned long division by shift and subtract, elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int j = 63; j >= 0; j--) begin
			r = {r[63:0], n[j]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(1024 * (2^(i/256) - 1))
	function automatic logic [EXP_W-1:0] make_exp(input int unsigned i);
		logic [63:0] y;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] k;
		logic [63:0] r;
		y    = mul_q62(LN2_Q62, 64'(i) << 54);
		sum  = ONE_Q62;
		term = ONE_Q62;
		for (k = 64'd1; k < 64'd40 && term != 64'd0; k = k + 64'd1) begin
			term = div_u64(mul_q62(term, y), k);
			sum  = sum + term;
		end
		r = ((sum - ONE_Q62) + (64'd1 << 51)) >> 52;
		return r[EXP_W-1:0];
	endfunction

	// round(-log2(sin((i + 0.5) * pi / 512)) * 256)
	function automatic logic [LOGSIN_W-1:0] make_logsin(input int unsigned i);
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] k;
		logic [63:0] frac;
		logic [63:0] x;
		logic [63:0] whole;
		logic [63:0] v;
		logic        sub;
		int          b;
		th    = PI_STEP * (64'd2 * 64'(i) + 64'd1);
		th2   = mul_q62(th, th);
		s     = th;
		term  = th;
		sub   = 1'b1;
		frac  = 64'd0;
		whole = 64'd0;
		// taylor series of sine
		for (k = 64'd1; k < 64'd40 && term != 64'd0; k = k + 64'd1) begin
			term = div_u64(mul_q62(term, th2), (64'd2 * k) * (64'd2 * k + 64'd1));
			if (sub) s = s - term;
			else     s = s + term;
			sub = !sub;
		end
		x = s;
		if (x == 64'd0) x = 64'd1;
		while (x < ONE_Q62) begin
			x     = x << 1;
			whole = whole + 64'd1;
		end
		// fractional log2 bits by repeated squaring
		for (b = 1; b <= 40; b++) begin
			x = mul_q62(x, x);
			if (x >= TWO_Q62) begin
				frac = frac | (64'd1 << (40 - b));
				x    = x >> 1;
			end
		end
		v = (whole << 40) - frac;
		v = (v + (64'd1 << 31)) >> 32;
		return v[LOGSIN_W-1:0];
	endfunction

	function automatic logsin_tbl_t build_logsin();
		logsin_tbl_t t;
		for (int i = 0; i < ROM_DEPTH; i++) t[i] = make_logsin(i);
		return t;
	endfunction

	function automatic exp_tbl_t build_exp();
		exp_tbl_t t;
		for (int i = 0; i < ROM_DEPTH; i++) t[i] = make_exp(i);
		return t;
	endfunction

	localparam logsin_tbl_t LOGSIN_ROM = build_logsin();
	localparam exp_tbl_t    EXP_ROM    = build_exp();

endpackage

// ----- rtl/core/lsexp_amp.sv -----
// exponent lookup, level shift and sign fold of the operator output stage
// combinational; depends on lsexp_pkg for the exponent table and the level type
module lsexp_amp import lsexp_pkg::*; (
	input  lsexp_lvl_t                  lvl,
	output logic signed [SAMPLE_W-1:0]  sample
);

	logic [EXP_W-1:0]       exp_val;
	logic [MAG_W-1:0]       mag;
	logic [LEVEL_W-9:0]     shift;
	logic [MAG_W-1:0]       mag_shifted;
	logic [SAMPLE_W-1:0]    q;

	always_comb begin
		// table is stored reversed against the fraction
		exp_val     = EXP_ROM[~lvl.level[7:0]];
		mag         = {1'b1, exp_val, 1'b0};
		shift       = lvl.level[LEVEL_W-1:8];
		// shifts past the magnitude width come out zero
		mag_shifted = mag >> shift;
		q           = {1'b0, mag_shifted[MAG_W-1:4]};
		sample      = lvl.neg ? signed'(~q) : signed'(q);
	end

endmodule

// ----- rtl/core/logsin_exp_operator_output.sv -----
// top level of the fm operator output stage: log-sine lookup, attenuation add, exponent stage
// depends on lsexp_pkg, lsexp_amp and logsin_exp_operator_output_macros.svh
`include "logsin_exp_operator_output_macros.svh"

// Takes one item (phase, attenuation) per clock while op_stall is low and returns one
// signed 9-bit sample per item, in order. An item passes three registers: the input
// register, the level register after the log-sine lookup and attenuation add, and the
// sample register after the exponent lookup and shift. When nothing stalls, the sustained
// rate is one item per cycle. A stall on the sample side backs up through the three stages,
// so op_stall rises only when all of them hold items. The negative half of the wave is the
// ones' complement of the magnitude, so a fully attenuated negative sample reads -1.
module logsin_exp_operator_output import lsexp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op_valid,
	output logic                        op_stall,
	input  logic [PHASE_W-1:0]          phase,
	input  logic [ATT_W-1:0]            attenuation,
	output logic                        sample_valid,
	input  logic                        sample_stall,
	output logic signed [SAMPLE_W-1:0]  sample
);

	logic                   v_s1;
	logic [PHASE_W-1:0]     phase_s1;
	logic [ATT_W-1:0]       att_s1;
	logic                   v_s2;
	lsexp_lvl_t             lvl_s2;
	logic                   valid_q;
	logic                   neg_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic                   en1;
	logic                   en2;
	logic                   en3;
	logic [7:0]             idx;
	lsexp_lvl_t             lvl_d;
	logic signed [SAMPLE_W-1:0] sample_d;

	assign en3 = !valid_q || !sample_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign op_stall = !en1;

	always_comb begin
		// bit 8 mirrors the quarter wave
		idx = phase_s1[8] ? ~phase_s1[7:0] : phase_s1[7:0];
		lvl_d.neg   = phase_s1[9];
		lvl_d.level = LEVEL_W'(LOGSIN_ROM[idx]) + LEVEL_W'(att_s1);
	end

	lsexp_amp u_amp (
		.lvl    (lvl_s2),
		.sample (sample_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= op_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && op_valid) begin
			phase_s1 <= phase;
			att_s1   <= attenuation;
		end
		if (en2 && v_s1) lvl_s2 <= lvl_d;
		if (en3 && v_s2) begin
			sample_q <= sample_d;
			neg_q    <= lvl_s2.neg;
		end
	end

	assign sample_valid = valid_q;
	assign sample       = sample_q;

	// sign bit of the sample follows the half-wave sign
	`LSE_ASSERT(a_sign_match, valid_q |-> (sample_q[SAMPLE_W-1] == neg_q))
	// log-sine peak plus full attenuation stays inside the level width
	`LSE_ASSERT(a_level_range, v_s2 |-> (lvl_s2.level <= LEVEL_W'(6232)))
	// back pressure on the input only with every stage full
	`LSE_ASSERT(a_stall_full, op_stall |-> (v_s1 && v_s2 && valid_q && sample_stall))
	// an accepted item sits in the input register next cycle
	`LSE_ASSERT(a_accept_lands, (op_valid && !op_stall) |=> v_s1)
	// an item leaving the level register is never dropped
	`LSE_ASSERT(a_s2_moves, (v_s2 && en3) |=> valid_q)

endmodule
